[src/owbm_pkg.sv]
// shared types and codes for the one-wire bus master
// no dependencies; imported by owbm_cfg, owbm_step and one_wire_bus_master_unit
package owbm_pkg;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_RPRE   = 4'd1,
        PH_RLOW   = 4'd2,
        PH_RDLY   = 4'd3,
        PH_RWATCH = 4'd4,
        PH_RTAIL  = 4'd5,
        PH_WLOW   = 4'd6,
        PH_WHOLD  = 4'd7,
        PH_WREC   = 4'd8,
        PH_DPRE   = 4'd9,
        PH_DLOW   = 4'd10,
        PH_DREL   = 4'd11,
        PH_DHOLD  = 4'd12
    } phase_t;

    typedef enum logic [1:0] {
        FUNC_NONE  = 2'd0,
        FUNC_RESET = 2'd1,
        FUNC_WRITE = 2'd2,
        FUNC_READ  = 2'd3
    } func_t;

    localparam logic [2:0] CFG_RESET_PRERELEASE = 3'd0;
    localparam logic [2:0] CFG_RESET_LOW        = 3'd1;
    localparam logic [2:0] CFG_PRESENCE_DELAY   = 3'd2;
    localparam logic [2:0] CFG_PRESENCE_TIMEOUT = 3'd3;
    localparam logic [2:0] CFG_RESET_TAIL       = 3'd4;
    localparam logic [2:0] CFG_SLOT_LOW         = 3'd5;
    localparam logic [2:0] CFG_SLOT_HOLD        = 3'd6;
    localparam logic [2:0] CFG_SLOT_RECOVERY    = 3'd7;

    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    typedef struct packed {
        logic [15:0] reset_prerelease_ticks;
        logic [15:0] reset_low_ticks;
        logic [15:0] presence_delay_ticks;
        logic [15:0] presence_timeout_ticks;
        logic [15:0] reset_tail_ticks;
        logic [7:0]  slot_low_ticks;
        logic [7:0]  slot_hold_ticks;
        logic [7:0]  slot_recovery_ticks;
    } cfg_t;

    typedef struct packed {
        phase_t      phase;
        logic [15:0] tick_count;
        logic [2:0]  bit_index;
        logic [7:0]  shift_byte;
        logic        presence_seen;
        logic [7:0]  last_read;
    } seq_state_t;

    typedef struct packed {
        logic        presence;
        logic [7:0]  read_data;
        logic        done_res;
        logic        busy_res;
        logic        pull_low;
    } result_t;

endpackage

[src/owbm_cfg.sv]
// timing register file for the one-wire bus master
// depends on owbm_pkg for cfg_t and the register index codes
module owbm_cfg
    import owbm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reset_prerelease_ticks <= 16'd50;
            cfg_reg.reset_low_ticks        <= 16'd500;
            cfg_reg.presence_delay_ticks   <= 16'd40;
            cfg_reg.presence_timeout_ticks <= 16'd500;
            cfg_reg.reset_tail_ticks       <= 16'd500;
            cfg_reg.slot_low_ticks         <= 8'd5;
            cfg_reg.slot_hold_ticks        <= 8'd65;
            cfg_reg.slot_recovery_ticks    <= 8'd2;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_RESET_PRERELEASE: cfg_reg.reset_prerelease_ticks <= cfg_data;
                CFG_RESET_LOW:        cfg_reg.reset_low_ticks        <= cfg_data;
                CFG_PRESENCE_DELAY:   cfg_reg.presence_delay_ticks   <= cfg_data;
                CFG_PRESENCE_TIMEOUT: cfg_reg.presence_timeout_ticks <= cfg_data;
                CFG_RESET_TAIL:       cfg_reg.reset_tail_ticks       <= cfg_data;
                CFG_SLOT_LOW:         cfg_reg.slot_low_ticks         <= cfg_data[7:0];
                CFG_SLOT_HOLD:        cfg_reg.slot_hold_ticks        <= cfg_data[7:0];
                CFG_SLOT_RECOVERY:    cfg_reg.slot_recovery_ticks    <= cfg_data[7:0];
                default:              cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[src/owbm_step.sv]
// next-state and result logic for one microsecond tick of the sequencer
// depends on owbm_pkg for the phase codes, cfg_t, seq_state_t and result_t
module owbm_step
    import owbm_pkg::*;
(
    input  cfg_t        cfg,
    input  seq_state_t  st,
    input  logic [1:0]  func,
    input  logic [7:0]  write_data,
    input  logic        line_level,
    output seq_state_t  st_next,
    output result_t     res
);

    // longest run of empty phases once fully empty write or read slots are taken out
    localparam int SETTLE_STEPS = 5;

    function automatic logic [15:0] phase_len(input phase_t p, input cfg_t c);
        logic [15:0] len;
        unique case (p)
            PH_RPRE:   len = c.reset_prerelease_ticks;
            PH_RLOW:   len = c.reset_low_ticks;
            PH_RDLY:   len = c.presence_delay_ticks;
            PH_RWATCH: len = c.presence_timeout_ticks;
            PH_RTAIL:  len = c.reset_tail_ticks;
            PH_WLOW:   len = {8'd0, c.slot_low_ticks};
            PH_WHOLD:  len = {8'd0, c.slot_hold_ticks};
            PH_WREC:   len = {8'd0, c.slot_recovery_ticks};
            PH_DPRE:   len = {8'd0, c.slot_low_ticks};
            PH_DLOW:   len = {8'd0, c.slot_low_ticks};
            PH_DREL:   len = {8'd0, c.slot_low_ticks};
            PH_DHOLD:  len = {8'd0, c.slot_hold_ticks};
            default:   len = 16'd0;
        endcase
        return len;
    endfunction

    function automatic seq_state_t advance(input seq_state_t s, input logic line);
        seq_state_t n;
        n = s;
        n.tick_count = 16'd0;
        unique case (s.phase)
            PH_RPRE:   n.phase = PH_RLOW;
            PH_RLOW:   n.phase = PH_RDLY;
            PH_RDLY:   n.phase = PH_RWATCH;
            PH_RWATCH: n.phase = PH_RTAIL;
            PH_WLOW:   n.phase = PH_WHOLD;
            PH_WHOLD:  n.phase = PH_WREC;
            PH_WREC:
            begin
                if (s.bit_index == 3'd7)
                begin
                    n.phase     = PH_IDLE;
                    n.bit_index = 3'd0;
                end
                else
                begin
                    n.bit_index  = s.bit_index + 3'd1;
                    n.shift_byte = {1'b0, s.shift_byte[7:1]};
                    n.phase      = PH_WLOW;
                end
            end
            PH_DPRE:   n.phase = PH_DLOW;
            PH_DLOW:   n.phase = PH_DREL;
            PH_DREL:
            begin
                n.shift_byte = {line, s.shift_byte[7:1]};
                n.phase      = PH_DHOLD;
            end
            PH_DHOLD:
            begin
                if (s.bit_index == 3'd7)
                begin
                    n.last_read = s.shift_byte;
                    n.phase     = PH_IDLE;
                    n.bit_index = 3'd0;
                end
                else
                begin
                    n.bit_index = s.bit_index + 3'd1;
                    n.phase     = PH_DLOW;
                end
            end
            default:
            begin
                n.phase     = PH_IDLE;
                n.bit_index = 3'd0;
            end
        endcase
        return n;
    endfunction

    // skip phases of zero length
    function automatic seq_state_t settle(input seq_state_t s, input logic line,
                                          input cfg_t c);
        seq_state_t  n;
        logic        wr_empty;
        logic        rd_empty;
        logic [3:0]  samples;
        logic [15:0] filled;
        n = s;
        wr_empty = (c.slot_low_ticks == 8'd0) && (c.slot_hold_ticks == 8'd0)
                   && (c.slot_recovery_ticks == 8'd0);
        rd_empty = (c.slot_low_ticks == 8'd0) && (c.slot_hold_ticks == 8'd0);
        if (wr_empty && (n.phase == PH_WLOW || n.phase == PH_WHOLD || n.phase == PH_WREC))
        begin
            // rest of the byte goes by on this tick
            n.phase      = PH_IDLE;
            n.bit_index  = 3'd0;
            n.tick_count = 16'd0;
        end
        else if (rd_empty && (n.phase == PH_DPRE || n.phase == PH_DLOW
                              || n.phase == PH_DREL || n.phase == PH_DHOLD))
        begin
            // every remaining bit samples this tick's line
            if (n.phase == PH_DHOLD)
                samples = 4'd7 - {1'b0, n.bit_index};
            else
                samples = 4'd8 - {1'b0, n.bit_index};
            filled       = {{8{line}}, n.shift_byte} >> samples;
            n.shift_byte = filled[7:0];
            n.last_read  = filled[7:0];
            n.phase      = PH_IDLE;
            n.bit_index  = 3'd0;
            n.tick_count = 16'd0;
        end
        else
        begin
            for (int i = 0; i < SETTLE_STEPS; i++)
            begin
                if (n.phase != PH_IDLE && phase_len(n.phase, c) == 16'd0)
                    n = advance(n, line);
            end
        end
        return n;
    endfunction

    logic        start;
    logic        write_empty;
    logic        read_empty;
    logic        busy;
    logic        drive;
    logic [16:0] tick_inc;
    seq_state_t  s0;
    seq_state_t  s1;
    seq_state_t  s2;

    assign write_empty = (cfg.slot_low_ticks == 8'd0) && (cfg.slot_hold_ticks == 8'd0)
                         && (cfg.slot_recovery_ticks == 8'd0);
    assign read_empty  = (cfg.slot_low_ticks == 8'd0) && (cfg.slot_hold_ticks == 8'd0);
    assign start       = (st.phase == PH_IDLE) && (func_t'(func) != FUNC_NONE);

    always_comb
    begin
        s0 = st;
        if (start)
        begin
            s0.tick_count = 16'd0;
            s0.bit_index  = 3'd0;
            unique case (func_t'(func))
                FUNC_RESET:
                begin
                    s0.presence_seen = 1'b0;
                    s0.phase         = PH_RPRE;
                end
                FUNC_WRITE:
                begin
                    s0.shift_byte = write_data;
                    // all slot phases empty: the whole byte goes by on this tick
                    s0.phase      = write_empty ? PH_IDLE : PH_WLOW;
                end
                default:
                begin
                    s0.shift_byte = 8'd0;
                    if (read_empty)
                    begin
                        // every bit samples this tick's line
                        s0.last_read = {8{line_level}};
                        s0.phase     = PH_IDLE;
                    end
                    else
                    begin
                        s0.phase = PH_DPRE;
                    end
                end
            endcase
        end
        // empty phases are only skipped up front on the start tick
        s1 = start ? settle(s0, line_level, cfg) : s0;

        busy = (s1.phase != PH_IDLE);
        unique case (s1.phase)
            PH_RLOW, PH_WLOW, PH_DLOW: drive = 1'b1;
            PH_WHOLD:                  drive = ~s1.shift_byte[0];
            default:                   drive = 1'b0;
        endcase

        tick_inc = {1'b0, s1.tick_count} + 17'd1;
        s2 = s1;
        if (busy)
        begin
            if (s1.phase == PH_RWATCH && !line_level)
            begin
                s2.presence_seen = 1'b1;
                s2 = settle(advance(s2, line_level), line_level, cfg);
            end
            else
            begin
                s2.tick_count = tick_inc[15:0];
                if (tick_inc >= {1'b0, phase_len(s1.phase, cfg)})
                    s2 = settle(advance(s2, line_level), line_level, cfg);
            end
        end
    end

    assign st_next = s2;

    assign res.pull_low  = drive;
    assign res.busy_res  = busy;
    assign res.done_res  = (start || st.phase != PH_IDLE) && (s2.phase == PH_IDLE);
    assign res.read_data = s2.last_read;
    assign res.presence  = s2.presence_seen;

endmodule

[src/one_wire_bus_master_unit.sv]
// one-wire bus master: one input beat per microsecond tick, one result beat per input beat
// result: the result of a beat is on m_tdata in the cycle after the beat is taken
// throughput: one beat per cycle; the whole tick is one pass of owbm_step into the
//   sequencer state and the result register; s_tready drops while a result beat waits
// reset: rst_n clears the sequencer to idle, the timing registers to their defaults
//   and clears m_tvalid; the result payload register itself is not reset
module one_wire_bus_master_unit
    import owbm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,   // write_data[7:0], line_level[8], zero[15:9]
    input  logic [1:0]            s_tuser,   // func[1:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,   // pull_low[0], busy_res[1], done_res[2],
                                             // read_data[10:3], presence[11], zero[15:12]
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t       cfg;
    seq_state_t state_reg;
    seq_state_t state_next;
    result_t    step_res;
    result_t    res_reg;
    logic       m_tvalid_reg;
    logic       accept;

    owbm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    owbm_step u_step (
        .cfg        (cfg),
        .st         (state_reg),
        .func       (s_tuser),
        .write_data (s_tdata[7:0]),
        .line_level (s_tdata[8]),
        .st_next    (state_next),
        .res        (step_res)
    );

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= '{phase: PH_IDLE, tick_count: 16'd0, bit_index: 3'd0,
                              shift_byte: 8'd0, presence_seen: 1'b0, last_read: 8'd0};
            m_tvalid_reg <= 1'b0;
        end
        else if (accept)
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
            res_reg <= step_res;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'd0, res_reg};

    // a beat taken mid-command always reports busy
    a_busy_held: assert property (@(posedge clk) disable iff (!rst_n)
        accept && state_reg.phase != PH_IDLE |=> res_reg.busy_res)
        else $error("busy dropped while a command was running");

    // a finishing beat leaves the sequencer idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept && step_res.done_res |=> state_reg.phase == PH_IDLE && res_reg.done_res)
        else $error("command finished but sequencer not idle");

    // the line is only driven inside a command
    a_pull_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept && step_res.pull_low |=> res_reg.busy_res)
        else $error("line driven low outside a command");

endmodule
